>>> src/lprt_pkg.sv
// ============================================================================
// lprt_pkg: shared types and constants of the longest prefix route table
// Holds the item structs, the token that walks the cell row, the write
// broadcast and the status and command codes.
// ============================================================================
`default_nettype none

package lprt_pkg;

  localparam int ROUTE_ENTRIES_DEF = 16;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_address;
    logic [3:0]  gateway_port;
    logic        direct_route;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] match_gateway;
    logic [3:0]  match_port;
    logic        match_direct;
    logic [31:0] match_mask;
  } out_item_t;

  // Token handed from cell to cell. On an add the route fields carry the
  // new route; on a lookup they carry the best route found so far.
  typedef struct packed {
    logic        valid;
    logic        command;
    logic [31:0] address;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  port;
    logic        direct;
    logic        same_hit;
    logic        free_hit;
    logic        found;
  } tok_t;

  // Write broadcast to every cell at the end of an add.
  typedef struct packed {
    logic        en;
    logic        replace;
    logic [31:0] key;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  port;
    logic        direct;
  } wr_t;

  function automatic logic [31:0] byte_rev(input logic [31:0] v);
    byte_rev = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

>>> src/lprt_cell.sv
// ============================================================================
// lprt_cell: one route slot of the table
// Holds one entry, updates the passing token and registers it for the next
// cell. Marks itself as the equal-key or first free slot for a later write.
// ============================================================================
`default_nettype none

module lprt_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lprt_pkg::tok_t tok_in,
  output lprt_pkg::tok_t     tok_out,
  input  wire lprt_pkg::wr_t wr
);
  import lprt_pkg::*;

  logic        valid_r;
  logic [31:0] key_r;
  logic [31:0] mask_r;
  logic [31:0] gateway_r;
  logic [3:0]  port_r;
  logic        direct_r;
  logic        same_mark_r, same_mark_nxt;
  logic        free_mark_r, free_mark_nxt;
  tok_t        tok_r, tok_nxt;
  logic        key_eq;
  logic        prefix_eq;
  logic        better;
  logic        wr_sel;

  assign key_eq    = (key_r == tok_in.address);
  assign prefix_eq = ((tok_in.address & mask_r) == (key_r & mask_r));
  assign better    = (byte_rev(mask_r) > byte_rev(tok_in.mask));

  always_comb begin
    tok_nxt       = tok_in;
    same_mark_nxt = same_mark_r;
    free_mark_nxt = free_mark_r;
    if (tok_in.valid) begin
      same_mark_nxt = valid_r && key_eq && !tok_in.same_hit;
      free_mark_nxt = !valid_r && !tok_in.free_hit;
      if (tok_in.command == CMD_ADD) begin
        if (valid_r && key_eq) begin
          tok_nxt.same_hit = 1'b1;
        end
        if (!valid_r) begin
          tok_nxt.free_hit = 1'b1;
        end
      end else begin
        // A zero mask ranks zero and so never beats the empty start.
        if (valid_r && prefix_eq && better) begin
          tok_nxt.mask    = mask_r;
          tok_nxt.gateway = gateway_r;
          tok_nxt.port    = port_r;
          tok_nxt.direct  = direct_r;
          tok_nxt.found   = 1'b1;
        end
      end
    end
  end

  assign wr_sel = wr.en && ((wr.replace && same_mark_r) || (!wr.replace && free_mark_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      same_mark_r <= 1'b0;
      free_mark_r <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      same_mark_r <= same_mark_nxt;
      free_mark_r <= free_mark_nxt;
      tok_r       <= tok_nxt;
      if (wr_sel) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      key_r     <= wr.key;
      mask_r    <= wr.mask;
      gateway_r <= wr.gateway;
      port_r    <= wr.port;
      direct_r  <= wr.direct;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

>>> src/longest_prefix_route_table_core.sv
// ============================================================================
// longest_prefix_route_table_core: IPv4 longest prefix match route table
// An accepted item passes as a token through head_r and then the row of
// route cells; its result is registered as it leaves the last cell. A new
// item is taken only after the last one has left the row (busy is low).
// Reset: synchronous, active low; clears every slot's valid bit at once.
// The receiver cannot stall: each result is shown for one cycle only.
// ============================================================================
`default_nettype none

module longest_prefix_route_table_core #(
  parameter int ROUTE_ENTRIES = lprt_pkg::ROUTE_ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lprt_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output lprt_pkg::out_item_t      out_item
);
  import lprt_pkg::*;

  // The table is a row of cells, one per slot. An accepted item becomes a
  // token in head_r and moves one cell per cycle. Each cell updates the
  // token: an add collects whether an equal key or a free slot was seen,
  // and each cell remembers whether it is that slot. A lookup keeps the
  // best matching route, ranked by the byte-reversed mask, and since only
  // a strictly better rank replaces it, ties stay with the lowest slot.

  tok_t      head_r, head_nxt;
  tok_t      chain [ROUTE_ENTRIES+1];
  tok_t      last;
  wr_t       wr;
  logic      busy_r, busy_nxt;
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      accept;

  assign accept = start && !busy_r;

  always_comb begin
    head_nxt          = head_r;
    head_nxt.valid    = 1'b0;
    if (accept) begin
      head_nxt.valid    = 1'b1;
      head_nxt.command  = in_item.command;
      head_nxt.address  = in_item.address;
      head_nxt.same_hit = 1'b0;
      head_nxt.free_hit = 1'b0;
      head_nxt.found    = 1'b0;
      // A lookup starts with an empty best route, which is also what a
      // miss reports.
      if (in_item.command == CMD_ADD) begin
        head_nxt.mask    = in_item.subnet_mask;
        head_nxt.gateway = in_item.gateway_address;
        head_nxt.port    = in_item.gateway_port;
        head_nxt.direct  = in_item.direct_route;
      end else begin
        head_nxt.mask    = '0;
        head_nxt.gateway = '0;
        head_nxt.port    = '0;
        head_nxt.direct  = 1'b0;
      end
    end
  end

  assign chain[0] = head_r;

  for (genvar gi = 0; gi < ROUTE_ENTRIES; gi++) begin : g_cell
    lprt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[gi]),
      .tok_out (chain[gi+1]),
      .wr      (wr)
    );
  end

  assign last = chain[ROUTE_ENTRIES];

  // When the token leaves the last cell the answer is settled: the result
  // is registered, and an add that found a slot is written into it in the
  // same edge. An equal key wins over a free slot.
  always_comb begin
    wr            = '0;
    wr.key        = last.address;
    wr.mask       = last.mask;
    wr.gateway    = last.gateway;
    wr.port       = last.port;
    wr.direct     = last.direct;
    out_item_nxt  = '0;
    if (last.command == CMD_ADD) begin
      if (last.same_hit) begin
        out_item_nxt.status = ST_REPLACED;
        wr.en               = last.valid;
        wr.replace          = 1'b1;
      end else if (last.free_hit) begin
        out_item_nxt.status = ST_ADDED;
        wr.en               = last.valid;
      end else begin
        out_item_nxt.status = ST_FULL;
      end
    end else begin
      out_item_nxt.status        = last.found ? ST_HIT : ST_MISS;
      out_item_nxt.match_gateway = last.gateway;
      out_item_nxt.match_port    = last.port;
      out_item_nxt.match_direct  = last.direct;
      out_item_nxt.match_mask    = last.mask;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (last.valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> dv/longest_prefix_route_table_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// longest_prefix_route_table_core_tb: self-checking bench for the route table
// Drives add and lookup commands through the start/busy handshake. A
// scoreboard keeps its own copy of the route slots and works out the result
// of each accepted item. Every out_valid strobe is checked field by field
// against the oldest outstanding expectation.
// ============================================================================

module longest_prefix_route_table_core_tb;

  import lprt_pkg::*;

  localparam int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF;
  localparam int RANDOM_ITEMS  = 850;
  // The slowest correct run is about 900 items plus sender gaps. The
  // limit is far above what that takes.
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_REPORTS   = 10;

  // A queued command, optionally held back until the table has gone quiet.
  typedef struct {
    in_item_t cmd;
    bit       drain_first;
  } pending_cmd_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  pending_cmd_t route_cmds[$];
  out_item_t    expected_results[$];

  // Scoreboard copy of the route slots.
  bit          slot_valid [ROUTE_ENTRIES];
  logic [31:0] slot_key   [ROUTE_ENTRIES];
  logic [31:0] slot_mask  [ROUTE_ENTRIES];
  logic [31:0] slot_gw    [ROUTE_ENTRIES];
  logic [3:0]  slot_port  [ROUTE_ENTRIES];
  logic        slot_direct[ROUTE_ENTRIES];

  int error_count = 0;
  int mismatch_count = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int status_seen[8];

  // Keys that the stimulus believes are stored, used to aim lookups and
  // replacements at real routes.
  logic [31:0] key_pool[$];

  longest_prefix_route_table_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model: applies one command to the slot copy and returns the
  // result the block must produce for it.
  // --------------------------------------------------------------------------
  function automatic out_item_t apply_route_command(in_item_t c);
    out_item_t   r;
    int          same_slot;
    int          free_slot;
    int          best_slot;
    int          tgt;
    logic [31:0] best_rank;
    logic [31:0] rank;
    r = '0;
    if (c.command == CMD_ADD) begin
      same_slot = -1;
      free_slot = -1;
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        if (slot_valid[i]) begin
          // Key equality is on all 32 bits, not the masked key.
          if (same_slot < 0 && slot_key[i] == c.address) same_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (same_slot >= 0) begin
        tgt = same_slot;
        r.status = ST_REPLACED;
      end else if (free_slot >= 0) begin
        tgt = free_slot;
        r.status = ST_ADDED;
      end else begin
        tgt = -1;
        r.status = ST_FULL;
      end
      if (tgt >= 0) begin
        slot_valid[tgt]  = 1'b1;
        slot_key[tgt]    = c.address;
        slot_mask[tgt]   = c.subnet_mask;
        slot_gw[tgt]     = c.gateway_address;
        slot_port[tgt]   = c.gateway_port;
        slot_direct[tgt] = c.direct_route;
      end
    end else begin
      // Rank is the byte-reversed mask; a zero mask has rank zero and so can
      // never beat the starting rank, which is why it never matches.
      best_slot = -1;
      best_rank = '0;
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        if (slot_valid[i] && ((c.address & slot_mask[i]) == (slot_key[i] & slot_mask[i])))
        begin
          rank = {<<8{slot_mask[i]}};
          if (rank > best_rank) begin
            best_rank = rank;
            best_slot = i;
          end
        end
      end
      if (best_slot >= 0) begin
        r.status        = ST_HIT;
        r.match_gateway = slot_gw[best_slot];
        r.match_port    = slot_port[best_slot];
        r.match_direct  = slot_direct[best_slot];
        r.match_mask    = slot_mask[best_slot];
      end else begin
        r.status = ST_MISS;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] prefix_mask(int len);
    if (len <= 0) return '0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic in_item_t route_add(logic [31:0] key, logic [31:0] mask,
                                         logic [31:0] gw, logic [3:0] port,
                                         logic dir);
    in_item_t c;
    c.command         = CMD_ADD;
    c.address         = key;
    c.subnet_mask     = mask;
    c.gateway_address = gw;
    c.gateway_port    = port;
    c.direct_route    = dir;
    return c;
  endfunction

  // Fields that a lookup ignores still carry random values so that they
  // toggle and so that the block is seen to disregard them.
  function automatic in_item_t route_lookup(logic [31:0] dest);
    in_item_t c;
    c.command         = CMD_LOOKUP;
    c.address         = dest;
    c.subnet_mask     = $urandom;
    c.gateway_address = $urandom;
    c.gateway_port    = 4'($urandom_range(15));
    c.direct_route    = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic void push_cmd(in_item_t c, bit drain);
    pending_cmd_t p;
    p.cmd = c;
    p.drain_first = drain;
    route_cmds.push_back(p);
  endfunction

  function automatic logic [31:0] random_mask();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick <= 2) return $urandom;   // non-contiguous as a rule
    return prefix_mask($urandom_range(32, 1));
  endfunction

  function automatic logic [31:0] pool_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Driver. Holds the item until taken, but a gap may drop start. Gaps are
  // random per cycle except for one long steady stretch; a command marked
  // drain_first waits until no result is outstanding. The quiet check only
  // trusts the expectation count on an edge where nothing was taken and no
  // result arrived, so the order of the clocked blocks cannot matter.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit taken;
    bit hold;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        void'(route_cmds.pop_front());
        sent_count++;
      end
      hold = 1'b0;
      if (route_cmds.size() == 0) begin
        hold = 1'b1;
      end else if (route_cmds[0].drain_first &&
                   (taken || out_valid || expected_results.size() != 0)) begin
        hold = 1'b1;
      end else if ((sent_count < 300 || sent_count >= 450) &&
                   $urandom_range(99) < 11) begin
        hold = 1'b1;
      end
      if (hold) begin
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        in_item <= route_cmds[0].cmd;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Sees the same accept condition as the block, predicts the result
  // at once (commands take effect in order of acceptance), then checks any
  // strobed result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(apply_route_command(in_item));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result with no command outstanding: status %0d gw %h",
                     out_item.status, out_item.match_gateway);
        end else begin
          want = expected_results.pop_front();
          status_seen[want.status]++;
          if (out_item.status !== want.status ||
              out_item.match_gateway !== want.match_gateway ||
              out_item.match_port !== want.match_port ||
              out_item.match_direct !== want.match_direct ||
              out_item.match_mask !== want.match_mask) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("ERROR: result mismatch at cycle %0d", cycle_count);
              $display("  expected status %0d gw %h port %0d direct %0d mask %h",
                       want.status, want.match_gateway, want.match_port,
                       want.match_direct, want.match_mask);
              $display("  actual   status %0d gw %h port %0d direct %0d mask %h",
                       out_item.status, out_item.match_gateway, out_item.match_port,
                       out_item.match_direct, out_item.match_mask);
            end
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("longest_prefix_route_table_core test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int          pick;
    logic [31:0] base;
    logic [31:0] keep;
    logic [31:0] key;

    // Directed part. Empty table first, then a zero-mask route that must
    // never match, nested prefixes, a tie on equal masks, a replacement,
    // a host route at the top of the address space and a non-contiguous mask
    // whose byte-reversed rank beats the /8 and /16 prefix routes.
    push_cmd(route_lookup(32'hC0A8_0101), 1'b0);
    push_cmd(route_add(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF, 1'b1), 1'b0);
    push_cmd(route_lookup(32'h0000_0000), 1'b0);
    push_cmd(route_add(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 4'h1, 1'b0), 1'b0);
    push_cmd(route_add(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 4'h2, 1'b1), 1'b0);
    push_cmd(route_add(32'h0A01_0001, 32'hFFFF_0000, 32'h0A01_00FE, 4'h3, 1'b0), 1'b0);
    push_cmd(route_lookup(32'h0A01_0203), 1'b0);
    push_cmd(route_lookup(32'h0A02_0304), 1'b0);
    push_cmd(route_lookup(32'h0B00_0000), 1'b0);
    push_cmd(route_add(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'h4, 1'b1), 1'b0);
    push_cmd(route_lookup(32'h0A7F_0000), 1'b0);
    push_cmd(route_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0, 1'b0), 1'b0);
    push_cmd(route_lookup(32'hFFFF_FFFF), 1'b0);
    push_cmd(route_add(32'h0A00_00FF, 32'h0000_00FF, 32'hC000_0201, 4'h5, 1'b1), 1'b0);
    push_cmd(route_lookup(32'h0A01_00FF), 1'b0);
    push_cmd(route_lookup(32'h0000_00FF), 1'b0);
    push_cmd(route_add(32'h0000_0000, 32'hFFFF_FFFF, 32'h7F00_0001, 4'h6, 1'b0), 1'b0);
    push_cmd(route_lookup(32'h0000_0000), 1'b0);
    key_pool = '{32'h0000_0000, 32'h0A00_0000, 32'h0A01_0000, 32'h0A01_0001,
                 32'hFFFF_FFFF, 32'h0A00_00FF};

    // Random part. Most lookups aim near stored keys so that prefixes nest
    // and compete; half the adds rewrite stored keys with fresh masks, and
    // once the table has filled, new keys run into the full table.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        keep = prefix_mask($urandom_range(32));
        base = pool_key();
        push_cmd(route_lookup((base & keep) | ($urandom & ~keep)), n == 200);
      end else if (pick < 50) begin
        push_cmd(route_lookup($urandom), n == 200);
      end else if (pick < 75) begin
        push_cmd(route_add(pool_key(), random_mask(), $urandom,
                           4'($urandom_range(15)), 1'($urandom_range(1))), n == 200);
      end else begin
        keep = prefix_mask($urandom_range(24, 8));
        key  = ($urandom_range(1)) ? $urandom : ((pool_key() & keep) | ($urandom & ~keep));
        if (key_pool.size() < ROUTE_ENTRIES) key_pool.push_back(key);
        push_cmd(route_add(key, random_mask(), $urandom,
                           4'($urandom_range(15)), 1'($urandom_range(1))), n == 200);
      end
      if (n == 600) route_cmds[route_cmds.size() - 1].drain_first = 1'b1;
    end

    // Closing burst: more fresh keys than there are slots, after the table
    // has gone quiet, so the table-full case is certain to be reached.
    for (int n = 0; n <= ROUTE_ENTRIES; n++)
      push_cmd(route_add(32'hC612_0000 + n, prefix_mask(31), $urandom, 4'(n), 1'(n)), n == 0);
    push_cmd(route_lookup(32'hC612_0001), 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (route_cmds.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (ROUTE_ENTRIES + 8) @(negedge clk);
    if (expected_results.size() != 0) begin
      error_count++;
      $display("ERROR: %0d results never arrived", expected_results.size());
    end

    $display("Run covered %0d commands over %0d cycles: %0d added, %0d replaced,",
             sent_count, cycle_count, status_seen[ST_ADDED], status_seen[ST_REPLACED]);
    $display("  %0d table full, %0d lookup hits, %0d lookup misses; %0d mismatches",
             status_seen[ST_FULL], status_seen[ST_HIT], status_seen[ST_MISS],
             mismatch_count);
    if (error_count == 0) begin
      $display("longest_prefix_route_table_core test passed");
    end else begin
      $display("longest_prefix_route_table_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lprt_pkg.sv
src/lprt_cell.sv
src/longest_prefix_route_table_core.sv
dv/longest_prefix_route_table_core_tb.sv
